@@ rtl/cps_pkg.sv @@
package cps_pkg;

   localparam int NUM_CABS       = 64;
   localparam int ROUND_WIDTH    = 32;
   localparam int CAB_IDX_WIDTH  = $clog2(NUM_CABS);
   localparam int WALK_WIDTH     = $clog2(NUM_CABS + 1);

   localparam logic [ROUND_WIDTH-1:0] ROUND_RESET   = ROUND_WIDTH'(30);
   localparam logic [7:0]             LIMIT_RESET   = 8'd30;
   localparam logic [7:0]             POLL_MARK     = 8'h80;
   localparam logic [WALK_WIDTH-1:0]  WALK_ONE      = WALK_WIDTH'(1);
   localparam logic [WALK_WIDTH-1:0]  WALK_TWO      = WALK_WIDTH'(2);
   localparam logic [WALK_WIDTH-1:0]  FIRST_CAB     = WALK_WIDTH'(3);
   localparam logic [WALK_WIDTH-1:0]  WALK_END      = WALK_WIDTH'(NUM_CABS);

   localparam logic OP_POLL   = 1'b0;
   localparam logic OP_RESULT = 1'b1;

   typedef struct packed {
      logic op;
      logic responded;
   } req_type;

   typedef struct packed {
      logic [5:0] cab_address;
      logic [7:0] poll_byte;
      logic       refresh_screens;
      logic       answered;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_RESULT,
      ST_EMIT
   } state_type;

   // next candidate on the walk; addresses 1 and 2 are never polled
   function automatic logic [WALK_WIDTH-1:0] next_cab(input logic [WALK_WIDTH-1:0] addr);
      logic [WALK_WIDTH-1:0] nxt;
      nxt = addr + WALK_ONE;
      if (nxt == WALK_ONE || nxt == WALK_TWO) begin
         nxt = FIRST_CAB;
      end
      return nxt;
   endfunction

endpackage

@@ rtl/cab_poll_scheduler_unit.sv @@
// Poll scheduler for a cab bus master. A poll word (op 0) walks the cab
// addresses upward from the last one polled, one table entry per cycle
// through the last-answer memory's single read port, and returns the chosen
// address with its poll byte. A result word (op 1) reads the current cab's
// entry, reports refresh_screens and, if the cab responded, records the
// answer round. The table needs no clearing pass after reset: per-entry
// valid flags make unwritten entries read as round zero. A new request
// word is taken while the previous result still waits on a stalled
// response channel; absence_limit may only be written while no request
// is in progress.
module cab_poll_scheduler_unit
   import cps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_word,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_word,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);

   state_type                state_ff, state_in;
   logic [7:0]               absence_limit_ff;
   logic [CAB_IDX_WIDTH-1:0] poll_address_ff, poll_address_in;
   logic [ROUND_WIDTH-1:0]   poll_round_ff, poll_round_in;
   logic [WALK_WIDTH-1:0]    cand_ff, cand_in;
   logic                     chk_valid_ff, chk_valid_in;
   logic [CAB_IDX_WIDTH-1:0] chk_addr_ff, chk_addr_in;
   logic                     responded_ff, responded_in;
   rsp_type                  res_ff, res_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_word_ff, rsp_word_in;
   logic [NUM_CABS-1:0]      entry_valid_ff, entry_valid_in;

   logic [ROUND_WIDTH-1:0]   last_answer_mem [NUM_CABS];
   logic [ROUND_WIDTH-1:0]   mem_rdata_ff;
   logic                     rd_entry_valid_ff;
   logic [CAB_IDX_WIDTH-1:0] mem_raddr;
   logic                     mem_we;

   logic [ROUND_WIDTH-1:0]   rd_round;
   logic [ROUND_WIDTH-1:0]   diff;
   logic [ROUND_WIDTH-1:0]   limit_ext;
   logic                     chosen;
   logic                     out_free;
   logic [7:0]               chk_addr8;
   logic [7:0]               poll_addr8;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         last_answer_mem[poll_address_ff] <= poll_round_ff;
      end
      mem_rdata_ff      <= last_answer_mem[mem_raddr];
      rd_entry_valid_ff <= entry_valid_ff[mem_raddr];
   end

   assign rd_round  = rd_entry_valid_ff ? mem_rdata_ff : '0;
   assign diff      = poll_round_ff - rd_round;
   assign limit_ext = ROUND_WIDTH'(absence_limit_ff);
   // silent cabs get a look only every fourth round, staggered by address
   assign chosen    = (diff < limit_ext) ||
                      ((diff > limit_ext) && ((poll_round_ff[1:0] + chk_addr_ff[1:0]) == 2'b00));
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign chk_addr8  = 8'(chk_addr_ff);
   assign poll_addr8 = 8'(poll_address_ff);

   always_comb begin
      state_in        = state_ff;
      poll_address_in = poll_address_ff;
      poll_round_in   = poll_round_ff;
      cand_in         = cand_ff;
      chk_valid_in    = 1'b0;
      chk_addr_in     = chk_addr_ff;
      responded_in    = responded_ff;
      res_in          = res_ff;
      entry_valid_in  = entry_valid_ff;
      mem_raddr       = poll_address_ff;
      mem_we          = 1'b0;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_word_in     = rsp_word_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_word.op == OP_POLL) begin
                  cand_in  = next_cab(WALK_WIDTH'(poll_address_ff));
                  state_in = ST_WALK;
               end else begin
                  responded_in = req_word.responded;
                  state_in     = ST_RESULT;
               end
            end
         end
         ST_WALK: begin
            // read the next candidate while the previous one is checked
            mem_raddr = (cand_ff < WALK_END) ? cand_ff[CAB_IDX_WIDTH-1:0] : '0;
            if (chk_valid_ff && chosen) begin
               poll_address_in     = chk_addr_ff;
               res_in.cab_address  = chk_addr8[5:0];
               res_in.poll_byte    = POLL_MARK | chk_addr8;
               res_in.refresh_screens = 1'b0;
               res_in.answered     = 1'b0;
               state_in            = ST_EMIT;
            end else if (cand_ff >= WALK_END) begin
               // wrap: address 0 is always polled and a new round begins
               poll_address_in     = '0;
               poll_round_in       = poll_round_ff + ROUND_WIDTH'(1);
               res_in.cab_address  = '0;
               res_in.poll_byte    = POLL_MARK;
               res_in.refresh_screens = 1'b0;
               res_in.answered     = 1'b0;
               state_in            = ST_EMIT;
            end else begin
               chk_valid_in = 1'b1;
               chk_addr_in  = cand_ff[CAB_IDX_WIDTH-1:0];
               cand_in      = next_cab(cand_ff);
            end
         end
         ST_RESULT: begin
            res_in.cab_address     = poll_addr8[5:0];
            res_in.poll_byte       = '0;
            res_in.refresh_screens = (diff > ROUND_WIDTH'(1));
            res_in.answered        = responded_ff;
            if (responded_ff) begin
               mem_we                          = 1'b1;
               entry_valid_in[poll_address_ff] = 1'b1;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         absence_limit_ff <= LIMIT_RESET;
         poll_address_ff  <= '0;
         poll_round_ff    <= ROUND_RESET;
         chk_valid_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         entry_valid_ff   <= '0;
      end else begin
         state_ff         <= state_in;
         poll_address_ff  <= poll_address_in;
         poll_round_ff    <= poll_round_in;
         chk_valid_ff     <= chk_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
         entry_valid_ff   <= entry_valid_in;
         if (csr_write_enable) begin
            absence_limit_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cand_ff      <= cand_in;
      chk_addr_ff  <= chk_addr_in;
      responded_ff <= responded_in;
      res_ff       <= res_in;
      rsp_word_ff  <= rsp_word_in;
   end

endmodule

@@ rtl/cps_checker.sv @@
module cps_checker
   import cps_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_word
);

   // a stalled word stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("response word changed while stalled");

   // a poll word carries the mark bit and its own address, and no result flags
   a_poll_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.poll_byte != 8'h00) |->
         rsp_word.poll_byte[7] && (rsp_word.poll_byte[5:0] == rsp_word.cab_address) &&
         !rsp_word.refresh_screens && !rsp_word.answered)
      else $error("poll byte does not match cab address");

   // addresses 1 and 2 are never polled
   a_skip_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.poll_byte != 8'h00) |->
         (rsp_word.cab_address != 6'd1) && (rsp_word.cab_address != 6'd2))
      else $error("reserved address polled");

   // nothing leaves the block straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind cab_poll_scheduler_unit cps_checker u_cps_checker (.*);
